FILE: hdl/dbq_pkg.sv
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared types and codes for the bounded deque with indexed insert.
// ----------------------------------------------------------------------------
`default_nettype none

package dbq_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ       = 3'd4,
      OP_INSERT     = 3'd5,
      OP_CLEAR      = 3'd6,
      OP_NOP        = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [4:0]         position;
      logic signed [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] data_out;
      logic [1:0]         status;
      logic [4:0]         count;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: hdl/dbq_ram.sv
// ----------------------------------------------------------------------------
// dbq_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_ram #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]    wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/dbq_slot.sv
// ----------------------------------------------------------------------------
// dbq_slot
// Ring address unit: slot = (front + offset) mod DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_slot #(
   parameter int DEPTH = 16
) (
   input  wire logic [$clog2(DEPTH)-1:0] front,
   input  wire logic [$clog2(DEPTH)-1:0] offset,
   output logic      [$clog2(DEPTH)-1:0] slot
);

   localparam int AW = $clog2(DEPTH);

   logic [AW:0] sum;

   always_comb begin
      sum = {1'b0, front} + {1'b0, offset};
      if (sum >= (AW+1)'(DEPTH)) begin
         slot = AW'(sum - (AW+1)'(DEPTH));
      end else begin
         slot = sum[AW-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/dbq_ctrl.sv
// ----------------------------------------------------------------------------
// dbq_ctrl
// Sequencer: decodes one operation, drives the ring address unit and the
// store, shifts entries one per cycle for insert, and holds the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_ctrl #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire dbq_pkg::req_word_type         req_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output dbq_pkg::rsp_word_type              rsp_word,
   output logic [$clog2(DEPTH)-1:0]           slot_front,
   output logic [$clog2(DEPTH)-1:0]           slot_offset,
   input  wire logic [$clog2(DEPTH)-1:0]      slot,
   output logic                               wr_en,
   output logic [$clog2(DEPTH)-1:0]           wr_addr,
   output logic [DATA_WIDTH-1:0]              wr_data,
   output logic                               rd_en,
   output logic [$clog2(DEPTH)-1:0]           rd_addr,
   input  wire logic [DATA_WIDTH-1:0]         rd_data,
   output logic [$clog2(DEPTH+1)-1:0]         occupancy
);

   import dbq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 5) ? CW : 5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_SHIFT,
      S_DRAIN,
      S_INS,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   opcode_type            op_ff, op_in;
   logic [4:0]            pos_ff, pos_in;
   logic [31:0]           val_ff, val_in;
   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         k_ff, k_in;
   logic [AW-1:0]         dst_ff, dst_in;
   logic [AW-1:0]         pend_dst_ff, pend_dst_in;
   logic                  pend_ff, pend_in;
   logic [31:0]           res_data_ff, res_data_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  full;
   logic                  empty;
   logic [PW-1:0]         pos_w;
   logic [PW-1:0]         count_w;
   logic [DATA_WIDTH-1:0] val_st;
   logic [31:0]           rd_word;

   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign pos_w      = PW'(pos_ff);
   assign count_w    = PW'(count_ff);
   assign val_st     = DATA_WIDTH'({32'd0, val_ff});
   assign rd_word    = 32'(rd_data);
   assign slot_front = front_ff;
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign occupancy  = count_ff;
   assign rd_addr    = slot;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      dst_in        = dst_ff;
      pend_dst_in   = pend_dst_ff;
      pend_in       = pend_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      slot_offset   = '0;
      wr_en         = 1'b0;
      wr_addr       = slot;
      wr_data       = val_st;
      rd_en         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = opcode_type'(req_word.operation);
               pos_in        = req_word.position;
               val_in        = req_word.value;
               res_data_in   = '0;
               res_status_in = ST_OK;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            case (op_ff)
               OP_PUSH_BACK: begin
                  slot_offset = AW'(count_ff);
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_PUSH_FRONT: begin
                  slot_offset = AW'(DEPTH - 1);
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     front_in = slot;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_POP_FRONT: begin
                  slot_offset = '0;
                  if (empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_RDWAIT;
                  end
               end
               OP_POP_BACK: begin
                  slot_offset = AW'(count_ff - CW'(1));
                  if (empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     count_in = count_ff - CW'(1);
                     state_in = S_RDWAIT;
                  end
               end
               OP_READ: begin
                  slot_offset = AW'(pos_ff);
                  if (pos_w >= count_w) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_RDWAIT;
                  end
               end
               OP_INSERT: begin
                  slot_offset = AW'(count_ff);
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else if (pos_w > count_w) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     dst_in   = slot;
                     k_in     = AW'(count_ff - CW'(1));
                     pend_in  = 1'b0;
                     state_in = (pos_w == count_w) ? S_INS : S_SHIFT;
                  end
               end
               OP_CLEAR: begin
                  front_in = '0;
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_RDWAIT: begin
            slot_offset = AW'(1);
            res_data_in = rd_word;
            if (op_ff == OP_POP_FRONT) begin
               front_in = slot;
               count_in = count_ff - CW'(1);
            end
            state_in = S_FINISH;
         end
         S_SHIFT: begin
            // read slot k while the word read last cycle lands one slot back
            slot_offset = k_ff;
            rd_en       = 1'b1;
            wr_en       = pend_ff;
            wr_addr     = pend_dst_ff;
            wr_data     = rd_data;
            pend_dst_in = dst_ff;
            dst_in      = slot;
            pend_in     = 1'b1;
            k_in        = k_ff - AW'(1);
            if (k_ff == AW'(pos_ff)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            wr_en    = 1'b1;
            wr_addr  = pend_dst_ff;
            wr_data  = rd_data;
            state_in = S_INS;
         end
         S_INS: begin
            wr_en    = 1'b1;
            wr_addr  = dst_ff;
            wr_data  = val_st;
            count_in = count_ff + CW'(1);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.data_out = res_data_ff;
               rsp_word_in.status   = res_status_ff;
               rsp_word_in.count    = 5'(count_ff);
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      k_ff          <= k_in;
      dst_ff        <= dst_in;
      pend_dst_ff   <= pend_dst_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_word_ff   <= rsp_word_in;
   end

endmodule

`default_nettype wire

FILE: hdl/bounded_deque_with_indexed_insert_top.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_insert_top
// Bounded double-ended queue of signed words in a ring, with indexed insert.
//
// A request word (req_valid/req_ready) carries an operation, a position and
// a value; each request yields exactly one response word (rsp_valid/
// rsp_ready) with the data read or popped, a status and the entry count.
// One request is in flight at a time; req_ready is high only while idle.
// Pop and read wait on the registered store read; an insert at position p
// with n entries first shifts the n - p entries from p onward one slot back
// (none when p == n). The response word turns valid in the same cycle that
// req_ready returns high.
// Insert moves one entry per cycle through the store's separate read and
// write ports, with the ring address unit computing one slot per cycle.
// The response sits in an output register; if one is still unaccepted and
// rsp_ready is low, the block holds the finished word and stays busy until
// it can load it. Reset empties the queue, drops any pending response and
// leaves req_ready high; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_indexed_insert_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire dbq_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output dbq_pkg::rsp_word_type      rsp_word
);

   import dbq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0]         slot_front;
   logic [AW-1:0]         slot_offset;
   logic [AW-1:0]         slot;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [CW-1:0]         occupancy;

   dbq_slot #(
      .DEPTH (DEPTH)
   ) u_slot (
      .front  (slot_front),
      .offset (slot_offset),
      .slot   (slot)
   );

   dbq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dbq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .slot_front  (slot_front),
      .slot_offset (slot_offset),
      .slot        (slot),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .occupancy   (occupancy)
   );

   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready
   ) else $error("request accepted while previous one in flight");

   a_occupancy_bound: assert property (
      @(posedge clock) disable iff (reset)
      occupancy <= CW'(DEPTH)
   ) else $error("occupancy exceeds depth");

   a_occupancy_step: assert property (
      @(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(occupancy)) |->
         (occupancy == $past(occupancy) + CW'(1) ||
          occupancy == $past(occupancy) - CW'(1) ||
          occupancy == '0)
   ) else $error("occupancy changed by more than one entry");

endmodule

`default_nettype wire
